@@ rtl/core/stv_pkg.sv @@
// Shared types, constants and helper functions of the vehicle step core.
`timescale 1ns / 1ps
package stv_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int CORDIC_N     = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int CW           = FRAC_BITS + 4;

    typedef logic signed [63:0]   t_s64;
    typedef logic signed [CW-1:0] t_cq;

    localparam t_s64 ONE       = t_s64'(64'd1 << FRAC_BITS);
    localparam t_s64 SAT_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_s64 LAT_CAP   = t_s64'(64'd50 << FRAC_BITS);
    localparam t_s64 YAW_CAP   = t_s64'(64'd10 << FRAC_BITS);
    localparam t_s64 PEDAL_N   = 64'sd100;
    localparam t_s64 DRAG_NUM  = 64'sd1872;
    localparam t_s64 DRAG_C    = t_s64'(64'd100000 << FRAC_BITS);
    localparam t_s64 STEER_ONE = 64'sd16384;
    localparam t_s64 MILLI     = 64'sd1000;
    localparam t_s64 MICRO     = 64'sd1000000;
    localparam t_s64 HEAD_B    = 64'sd65536000000000;
    localparam t_s64 HEAD_C    = t_s64'(64'd6283185307 << FRAC_BITS);
    localparam t_cq  CORDIC_X0 = t_cq'((64'd607252935 << FRAC_BITS) / 64'd1000000000);

    localparam logic [31:0] ATAN_TURN [ATAN_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    typedef enum logic [2:0] {
        CFG_MASS, CFG_DT, CFG_C1, CFG_C2, CFG_L1, CFG_L2, CFG_JZ, CFG_CAP
    } t_cfg_idx;

    typedef enum logic [5:0] {
        U_DRAG, U_ANUM, U_ACC, U_DV, U_VNEW,
        U_PROD, U_KCL, U_KA, U_KB, U_KRR, U_DQ, U_RV, U_YV,
        U_T1, U_T2, U_T3, U_TORQ, U_RDOT, U_F1, U_F2, U_F3, U_FY,
        U_A1, U_A2, U_AYD, U_ZERO,
        U_DR, U_RNEW, U_DVY, U_VYNEW, U_COS,
        U_WX1, U_WX2, U_WX, U_WY1, U_WY2, U_WY,
        U_DX, U_PX, U_DY, U_PY, U_DH1, U_DH2, U_LAST
    } t_uop;

    typedef enum logic [1:0] {K_MD, K_ALU, K_CORD, K_END} t_kind;
    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT} t_ctrl_state;
    typedef enum logic [2:0] {MD_IDLE, MD_MUL, MD_CHK, MD_DIV, MD_FIN} t_md_phase;

    typedef struct packed {
        t_uop uop;
        logic load;
        logic md_start;
        logic cd_start;
        logic alu_en;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic md_done;
        logic cd_done;
        logic skip_lat;
        logic out_free;
    } t_stat;

    function automatic t_s64 sadd(t_s64 a, t_s64 b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(SAT_MAX)) return SAT_MAX;
        else if (s < -65'(SAT_MAX)) return -SAT_MAX;
        else return s[63:0];
    endfunction

    function automatic t_s64 clampv(t_s64 x, t_s64 lo, t_s64 hi);
        if (x < lo) return lo;
        else if (x > hi) return hi;
        else return x;
    endfunction

    function automatic logic [63:0] mag(t_s64 a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    function automatic t_kind uop_kind(t_uop u);
        case (u)
            U_ANUM, U_VNEW, U_PROD, U_KCL, U_KRR, U_TORQ, U_FY, U_AYD, U_ZERO,
            U_RNEW, U_VYNEW, U_WX, U_WY, U_PX, U_PY: return K_ALU;
            U_COS:  return K_CORD;
            U_LAST: return K_END;
            default: return K_MD;
        endcase
    endfunction

    function automatic t_uop uop_next(t_uop u, logic skip);
        case (u)
            U_PROD:  return skip ? U_ZERO : U_KCL;
            U_AYD:   return U_DR;
            U_LAST:  return U_LAST;
            default: return t_uop'(6'(u) + 6'd1);
        endcase
    endfunction

endpackage

@@ rtl/core/single_track_vehicle_step_core.sv @@
// Top level of the single-track vehicle Euler step core.
// Each multiply-divide runs in the shared serial unit (its division is skipped when it saturates),
// 13 of them per step when speed or steer is zero and 27 otherwise, besides the ALU steps,
// the CORDIC and the handshake; a word also waits on any output stall.
// One word in flight; the next is taken once the result is in the output register.
// Synchronous reset restores register defaults and clears the vehicle state.
`timescale 1ns / 1ps
module single_track_vehicle_step_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // throttle_pct, brake_pct, road_wheel_angle
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [151:0] m_axis_tdata,   // long_speed, lat_speed, yaw_rate_out,
                                         // heading_out, world_x, world_y
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [22:0]  i_cfg_data
);
    stv_pkg::t_cmd  w_cmd;
    stv_pkg::t_stat w_stat;

    stv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    stv_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_word   (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_word  (m_axis_tdata)
    );
endmodule

@@ rtl/core/stv_muldiv.sv @@
// Shared serial multiply-divide unit: sat(trunc(a*b/c)) at full width.
`timescale 1ns / 1ps
module stv_muldiv (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  stv_pkg::t_s64 i_a,
    input  stv_pkg::t_s64 i_b,
    input  stv_pkg::t_s64 i_c,
    output logic          o_done,
    output stv_pkg::t_s64 o_q
);
    stv_pkg::t_md_phase r_phase;
    logic [5:0]         r_cnt;
    logic               r_done;
    logic [63:0]        r_am, r_bm, r_cm;
    logic               r_neg;
    logic [127:0]       r_acc;
    stv_pkg::t_s64      r_q;

    logic [127:0] w_mul;
    logic [63:0]  w_shift, w_sub, w_capq;
    logic         w_take, w_sat;

    always_comb begin
        w_mul   = {r_acc[126:0], 1'b0} + (r_bm[r_cnt] ? {64'b0, r_am} : 128'b0);
        w_shift = {r_acc[126:64], r_acc[63]};
        w_take  = r_acc[127] || (w_shift >= r_cm);
        w_sub   = w_shift - r_cm;
        w_sat   = (r_cm == 64'd0) || (r_acc[127:64] >= r_cm);
        w_capq  = r_acc[63] ? 64'(stv_pkg::SAT_MAX) : r_acc[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= stv_pkg::MD_IDLE;
            r_cnt   <= 6'd0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                stv_pkg::MD_IDLE: begin
                    if (i_start) begin
                        r_phase <= stv_pkg::MD_MUL;
                        r_cnt   <= 6'd63;
                    end
                end
                stv_pkg::MD_MUL: begin
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) r_phase <= stv_pkg::MD_CHK;
                end
                stv_pkg::MD_CHK: begin
                    if (w_sat) begin
                        r_phase <= stv_pkg::MD_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_phase <= stv_pkg::MD_DIV;
                        r_cnt   <= 6'd63;
                    end
                end
                stv_pkg::MD_DIV: begin
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) r_phase <= stv_pkg::MD_FIN;
                end
                stv_pkg::MD_FIN: begin
                    r_phase <= stv_pkg::MD_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_phase <= stv_pkg::MD_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_phase)
            stv_pkg::MD_IDLE: begin
                if (i_start) begin
                    r_am  <= stv_pkg::mag(i_a);
                    r_bm  <= stv_pkg::mag(i_b);
                    r_cm  <= stv_pkg::mag(i_c);
                    r_neg <= i_a[63] ^ i_b[63] ^ i_c[63];
                    r_acc <= 128'd0;
                end
            end
            stv_pkg::MD_MUL: r_acc <= w_mul;
            stv_pkg::MD_CHK: begin
                if (w_sat) r_q <= r_neg ? -stv_pkg::SAT_MAX : stv_pkg::SAT_MAX;
            end
            stv_pkg::MD_DIV: begin
                r_acc <= w_take ? {w_sub, r_acc[62:0], 1'b1} : {w_shift, r_acc[62:0], 1'b0};
            end
            stv_pkg::MD_FIN: r_q <= r_neg ? -stv_pkg::t_s64'(w_capq) : stv_pkg::t_s64'(w_capq);
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule

@@ rtl/core/stv_cordic.sv @@
// Iterative CORDIC giving cosine and sine of the heading.
`timescale 1ns / 1ps
module stv_cordic (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [15:0]   i_heading,
    output logic          o_done,
    output stv_pkg::t_s64 o_cos,
    output stv_pkg::t_s64 o_sin
);
    localparam logic [4:0] LAST_I = 5'(stv_pkg::CORDIC_N - 1);

    logic               r_busy, r_done;
    logic [4:0]         r_i;
    stv_pkg::t_cq       r_x, r_y;
    logic signed [33:0] r_z;
    logic               r_flip;

    logic               w_flip;
    logic [31:0]        w_a;
    stv_pkg::t_cq       w_ys, w_xs;
    logic signed [33:0] w_at;

    always_comb begin
        w_flip = (i_heading[15:14] == 2'd1) || (i_heading[15:14] == 2'd2);
        w_a    = {i_heading[15] ^ w_flip, i_heading[14:0], 16'd0};
        w_ys   = r_y >>> r_i;
        w_xs   = r_x >>> r_i;
        w_at   = signed'({2'b00, stv_pkg::ATAN_TURN[r_i]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= 5'd0;
            end else if (r_busy) begin
                r_i <= r_i + 5'd1;
                if (r_i == LAST_I) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= stv_pkg::CORDIC_X0;
            r_y    <= '0;
            r_z    <= 34'(signed'(w_a));
            r_flip <= w_flip;
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_flip ? -stv_pkg::t_s64'(r_x) : stv_pkg::t_s64'(r_x);
    assign o_sin  = r_flip ? -stv_pkg::t_s64'(r_y) : stv_pkg::t_s64'(r_y);
endmodule

@@ rtl/core/stv_datapath.sv @@
// Datapath: configuration, vehicle state, temporaries, shared units and result word.
`timescale 1ns / 1ps
module stv_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  stv_pkg::t_cmd  i_cmd,
    output stv_pkg::t_stat o_stat,
    input  logic [31:0]    i_in_word,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [22:0]    i_cfg_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [151:0]   o_out_word
);
    // configuration
    logic [15:0] r_mass, r_jz;
    logic [16:0] r_dt;
    logic [19:0] r_c1, r_c2;
    logic [13:0] r_l1, r_l2;
    logic [22:0] r_cap;
    // state
    logic [22:0]        r_vl;
    logic signed [22:0] r_vy;
    logic signed [20:0] r_r;
    logic [15:0]        r_head;
    logic [31:0]        r_px, r_py;
    // item and temporaries
    logic [6:0]         r_thr, r_brk;
    logic signed [15:0] r_steer;
    logic [22:0]        r_tv;
    logic signed [22:0] r_tvy;
    logic signed [20:0] r_tr;
    logic [33:0]        r_c1l1, r_c2l2;
    stv_pkg::t_s64      r_t1, r_t2, r_t3, r_kcl, r_krr, r_dq, r_rv, r_yv;
    stv_pkg::t_s64      r_rdot, r_aydot;
    logic               r_ovalid;
    logic [151:0]       r_out;

    stv_pkg::t_s64 w_a, w_b, w_c, w_q, w_cos, w_sin, w_force, w_sum, w_clip;
    stv_pkg::t_s64 w_m, w_jz, w_dt, w_vl, w_tv, w_vy, w_tvy, w_r, w_tr;
    logic          w_md_done, w_cd_done;
    logic [6:0]    w_thr_in, w_brk_in;
    logic [33:0]   w_vdrag;
    logic [15:0]   w_head_n;

    always_comb begin
        w_m     = stv_pkg::t_s64'((r_mass == 16'd0) ? 16'd1 : r_mass);
        w_jz    = stv_pkg::t_s64'((r_jz == 16'd0) ? 16'd1 : r_jz);
        w_dt    = stv_pkg::t_s64'(r_dt);
        w_vl    = stv_pkg::t_s64'(r_vl);
        w_tv    = stv_pkg::t_s64'(r_tv);
        w_vy    = stv_pkg::t_s64'(r_vy);
        w_tvy   = stv_pkg::t_s64'(r_tvy);
        w_r     = stv_pkg::t_s64'(r_r);
        w_tr    = stv_pkg::t_s64'(r_tr);
        w_vdrag = 34'(r_vl) * 34'(stv_pkg::DRAG_NUM);
        w_force = (stv_pkg::t_s64'(r_thr) - stv_pkg::t_s64'(r_brk)) * stv_pkg::PEDAL_N
                  * stv_pkg::ONE;
        w_thr_in = (i_in_word[6:0] > 7'd100) ? 7'd100 : i_in_word[6:0];
        w_brk_in = (i_in_word[13:7] > 7'd100) ? 7'd100 : i_in_word[13:7];
        w_head_n = r_head + r_t1[15:0];
    end

    always_comb begin
        w_a = '0;
        w_b = '0;
        w_c = stv_pkg::ONE;
        case (i_cmd.uop)
            stv_pkg::U_DRAG: begin
                w_a = stv_pkg::t_s64'(w_vdrag); w_b = w_vl; w_c = stv_pkg::DRAG_C;
            end
            stv_pkg::U_ACC:  begin w_a = r_t1; w_b = 64'sd1; w_c = w_m; end
            stv_pkg::U_DV:   begin w_a = r_t1; w_b = w_dt; end
            stv_pkg::U_KA:   begin
                w_a = stv_pkg::t_s64'(r_c1l1); w_b = stv_pkg::t_s64'(r_l1); w_c = 64'sd1;
            end
            stv_pkg::U_KB:   begin
                w_a = stv_pkg::t_s64'(r_c2l2); w_b = stv_pkg::t_s64'(r_l2); w_c = 64'sd1;
            end
            stv_pkg::U_DQ:   begin
                w_a = stv_pkg::t_s64'(r_steer); w_b = stv_pkg::ONE; w_c = stv_pkg::STEER_ONE;
            end
            stv_pkg::U_RV:   begin w_a = w_r; w_b = stv_pkg::ONE; w_c = w_tv; end
            stv_pkg::U_YV:   begin w_a = w_vy; w_b = stv_pkg::ONE; w_c = w_tv; end
            stv_pkg::U_T1:   begin w_a = r_krr; w_b = r_rv; w_c = stv_pkg::MICRO; end
            stv_pkg::U_T2:   begin w_a = r_kcl; w_b = r_yv; w_c = stv_pkg::MILLI; end
            stv_pkg::U_T3:   begin
                w_a = stv_pkg::t_s64'(r_c1l1); w_b = r_dq; w_c = stv_pkg::MILLI;
            end
            stv_pkg::U_RDOT: begin w_a = r_t1; w_b = 64'sd1; w_c = w_jz; end
            stv_pkg::U_F1:   begin w_a = r_kcl; w_b = r_rv; w_c = stv_pkg::MILLI; end
            stv_pkg::U_F2:   begin
                w_a = stv_pkg::t_s64'(r_c1) + stv_pkg::t_s64'(r_c2); w_b = r_yv; w_c = 64'sd1;
            end
            stv_pkg::U_F3:   begin w_a = stv_pkg::t_s64'(r_c1); w_b = r_dq; w_c = 64'sd1; end
            stv_pkg::U_A1:   begin w_a = r_t1; w_b = 64'sd1; w_c = w_m; end
            stv_pkg::U_A2:   begin w_a = w_tv; w_b = w_r; end
            stv_pkg::U_DR:   begin w_a = r_rdot; w_b = w_dt; end
            stv_pkg::U_DVY:  begin w_a = r_aydot; w_b = w_dt; end
            stv_pkg::U_WX1:  begin w_a = w_tv; w_b = w_cos; end
            stv_pkg::U_WX2:  begin w_a = w_tvy; w_b = w_sin; end
            stv_pkg::U_WY1:  begin w_a = w_tv; w_b = w_sin; end
            stv_pkg::U_WY2:  begin w_a = w_tvy; w_b = w_cos; end
            stv_pkg::U_DX:   begin w_a = r_t3; w_b = w_dt; end
            stv_pkg::U_DY:   begin w_a = r_t2; w_b = w_dt; end
            stv_pkg::U_DH1:  begin w_a = w_tr; w_b = w_dt; end
            stv_pkg::U_DH2:  begin w_a = r_t1; w_b = stv_pkg::HEAD_B; w_c = stv_pkg::HEAD_C; end
            default: ;
        endcase
    end

    always_comb begin
        w_sum  = '0;
        w_clip = '0;
        case (i_cmd.uop)
            stv_pkg::U_VNEW: begin
                w_sum  = stv_pkg::sadd(w_vl, r_t1);
                w_clip = stv_pkg::clampv(w_sum, '0, stv_pkg::t_s64'(r_cap));
            end
            stv_pkg::U_RNEW: begin
                w_sum  = stv_pkg::sadd(w_r, r_t1);
                w_clip = stv_pkg::clampv(w_sum, -stv_pkg::YAW_CAP, stv_pkg::YAW_CAP);
            end
            stv_pkg::U_VYNEW: begin
                w_sum  = stv_pkg::sadd(w_vy, r_t1);
                w_clip = stv_pkg::clampv(w_sum, -stv_pkg::LAT_CAP, stv_pkg::LAT_CAP);
            end
            default: ;
        endcase
    end

    stv_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.md_start),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_c     (w_c),
        .o_done  (w_md_done),
        .o_q     (w_q)
    );

    stv_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.cd_start),
        .i_heading (r_head),
        .o_done    (w_cd_done),
        .o_cos     (w_cos),
        .o_sin     (w_sin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass   <= 16'd1573;
            r_dt     <= 17'd32768;
            r_c1     <= 20'd16000;
            r_c2     <= 20'd16000;
            r_l1     <= 14'd1100;
            r_l2     <= 14'd1580;
            r_jz     <= 16'd2873;
            r_cap    <= 23'd3276800;
            r_vl     <= '0;
            r_vy     <= '0;
            r_r      <= '0;
            r_head   <= '0;
            r_px     <= '0;
            r_py     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (stv_pkg::t_cfg_idx'(i_cfg_idx))
                    stv_pkg::CFG_MASS: r_mass <= i_cfg_data[15:0];
                    stv_pkg::CFG_DT:   r_dt   <= i_cfg_data[16:0];
                    stv_pkg::CFG_C1:   r_c1   <= i_cfg_data[19:0];
                    stv_pkg::CFG_C2:   r_c2   <= i_cfg_data[19:0];
                    stv_pkg::CFG_L1:   r_l1   <= i_cfg_data[13:0];
                    stv_pkg::CFG_L2:   r_l2   <= i_cfg_data[13:0];
                    stv_pkg::CFG_JZ:   r_jz   <= i_cfg_data[15:0];
                    stv_pkg::CFG_CAP:  r_cap  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.alu_en && i_cmd.uop == stv_pkg::U_PX) r_px <= r_px + r_t1[31:0];
            if (i_cmd.alu_en && i_cmd.uop == stv_pkg::U_PY) r_py <= r_py + r_t1[31:0];
            if (i_cmd.commit) begin
                r_vl     <= r_tv;
                r_vy     <= r_tvy;
                r_r      <= r_tr;
                r_head   <= w_head_n;
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_thr   <= w_thr_in;
            r_brk   <= w_brk_in;
            r_steer <= i_in_word[29:14];
        end
        if (i_cmd.commit) begin
            r_out <= {5'd0, r_py, r_px, w_head_n, r_tr, r_tvy, r_tv};
        end
        if (w_md_done) begin
            case (i_cmd.uop)
                stv_pkg::U_DQ:   r_dq   <= w_q;
                stv_pkg::U_RV:   r_rv   <= w_q;
                stv_pkg::U_YV:   r_yv   <= w_q;
                stv_pkg::U_RDOT: r_rdot <= w_q;
                stv_pkg::U_KB, stv_pkg::U_T2, stv_pkg::U_F2, stv_pkg::U_A2,
                stv_pkg::U_WX2, stv_pkg::U_WY2: r_t2 <= w_q;
                stv_pkg::U_T3, stv_pkg::U_F3: r_t3 <= w_q;
                default: r_t1 <= w_q;
            endcase
        end
        if (i_cmd.alu_en) begin
            case (i_cmd.uop)
                stv_pkg::U_ANUM:  r_t1 <= w_force - r_t1;
                stv_pkg::U_VNEW:  r_tv <= w_clip[22:0];
                stv_pkg::U_PROD: begin
                    r_c1l1 <= 34'(r_c1) * 34'(r_l1);
                    r_c2l2 <= 34'(r_c2) * 34'(r_l2);
                end
                stv_pkg::U_KCL:   r_kcl <= stv_pkg::t_s64'(r_c2l2) - stv_pkg::t_s64'(r_c1l1);
                stv_pkg::U_KRR:   r_krr <= r_t1 + r_t2;
                stv_pkg::U_TORQ:  r_t1 <= stv_pkg::sadd(stv_pkg::sadd(-r_t1, r_t2), r_t3);
                stv_pkg::U_FY:    r_t1 <= stv_pkg::sadd(stv_pkg::sadd(r_t1, -r_t2), r_t3);
                stv_pkg::U_AYD:   r_aydot <= stv_pkg::sadd(r_t1, -r_t2);
                stv_pkg::U_ZERO: begin
                    r_rdot  <= '0;
                    r_aydot <= '0;
                end
                stv_pkg::U_RNEW:  r_tr  <= w_clip[20:0];
                stv_pkg::U_VYNEW: r_tvy <= w_clip[22:0];
                stv_pkg::U_WX:    r_t3  <= stv_pkg::sadd(r_t1, -r_t2);
                stv_pkg::U_WY:    r_t2  <= stv_pkg::sadd(r_t1, r_t2);
                default: ;
            endcase
        end
    end

    assign o_stat.md_done  = w_md_done;
    assign o_stat.cd_done  = w_cd_done;
    assign o_stat.skip_lat = (r_tv == 23'd0) || (r_steer == 16'sd0);
    assign o_stat.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid     = r_ovalid;
    assign o_out_word      = r_out;
endmodule

@@ rtl/core/stv_ctrl.sv @@
// Controller: steps the micro-operation sequence of one vehicle step.
`timescale 1ns / 1ps
module stv_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  stv_pkg::t_stat i_stat,
    output stv_pkg::t_cmd  o_cmd
);
    stv_pkg::t_ctrl_state r_state, n_state;
    stv_pkg::t_uop        r_uop, n_uop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stv_pkg::ST_IDLE;
            r_uop   <= stv_pkg::U_DRAG;
        end else begin
            r_state <= n_state;
            r_uop   <= n_uop;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_uop          = r_uop;
        o_in_ready     = 1'b0;
        o_cmd.uop      = r_uop;
        o_cmd.load     = 1'b0;
        o_cmd.md_start = 1'b0;
        o_cmd.cd_start = 1'b0;
        o_cmd.alu_en   = 1'b0;
        o_cmd.commit   = 1'b0;
        unique case (r_state)
            stv_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_uop      = stv_pkg::U_DRAG;
                    n_state    = stv_pkg::ST_RUN;
                end
            end
            stv_pkg::ST_RUN: begin
                unique case (stv_pkg::uop_kind(r_uop))
                    stv_pkg::K_MD: begin
                        o_cmd.md_start = 1'b1;
                        n_state        = stv_pkg::ST_WAIT;
                    end
                    stv_pkg::K_CORD: begin
                        o_cmd.cd_start = 1'b1;
                        n_state        = stv_pkg::ST_WAIT;
                    end
                    stv_pkg::K_ALU: begin
                        o_cmd.alu_en = 1'b1;
                        n_uop        = stv_pkg::uop_next(r_uop, i_stat.skip_lat);
                    end
                    stv_pkg::K_END: begin
                        if (i_stat.out_free) begin
                            o_cmd.commit = 1'b1;
                            n_state      = stv_pkg::ST_IDLE;
                        end
                    end
                    default: n_state = stv_pkg::ST_IDLE;
                endcase
            end
            stv_pkg::ST_WAIT: begin
                if (i_stat.md_done || i_stat.cd_done) begin
                    n_uop   = stv_pkg::uop_next(r_uop, i_stat.skip_lat);
                    n_state = stv_pkg::ST_RUN;
                end
            end
            default: n_state = stv_pkg::ST_IDLE;
        endcase
    end
endmodule
